// File: hdl/stp_pkg.sv
// ----------------------------------------------------------------------------
// Stepper command driver package
// Shared widths, register indexes, microcode encodings and the control
// program of the two-axis stepper command driver.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

   // Default number of full steps in one motor turn.
   localparam int STEPS_PER_TURN_DEF = 400;

   // Fixed field widths.
   localparam int CMD_W      = 8;
   localparam int OUT_POS_W  = 9;
   localparam int COUNT_W    = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 1;
   localparam int PC_W       = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_H_POLARITY    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_V_POLARITY    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_ACT_LO = 2'd2;

   // Command opcodes.
   localparam logic OPC_MOVE      = 1'b0;
   localparam logic OPC_CALIBRATE = 1'b1;

   // Result item kinds.
   localparam logic KIND_PULSE  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // Axis codes.
   localparam logic AXIS_H = 1'b0;
   localparam logic AXIS_V = 1'b1;

   // Program addresses.
   localparam logic [PC_W-1:0] PC_IDLE   = 3'd0;
   localparam logic [PC_W-1:0] PC_LOAD   = 3'd1;
   localparam logic [PC_W-1:0] PC_FOLD   = 3'd2;
   localparam logic [PC_W-1:0] PC_STORE  = 3'd3;
   localparam logic [PC_W-1:0] PC_PULSE  = 3'd4;
   localparam logic [PC_W-1:0] PC_NEXT   = 3'd5;
   localparam logic [PC_W-1:0] PC_REPORT = 3'd6;
   localparam logic [PC_W-1:0] PC_CLEAR  = 3'd7;

   // Datapath operation selected by a control word.
   typedef enum logic [2:0] {
      OP_ACCEPT,
      OP_LOAD,
      OP_FOLD,
      OP_STORE,
      OP_PULSE,
      OP_NEXT_AXIS,
      OP_REPORT,
      OP_CLEAR
   } op_type;

   // Jump condition of a control word.
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_CALIBRATE,
      COND_OUT_RANGE,
      COND_COUNT_LEFT,
      COND_AXIS_H
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [PC_W-1:0]   target;
   } ucode_type;

   // Status flags from the datapath to the sequencer.
   typedef struct packed {
      logic req_valid;
      logic req_calibrate;
      logic out_range;
      logic count_nz;
      logic axis_v;
      logic slot_free;
   } status_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      op_type op;
      logic   go;
   } ctrl_type;

   // Control program. A step falls through to the next address unless its
   // condition holds, in which case it jumps to its target.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         PC_IDLE:   w = '{op: OP_ACCEPT,    cond: COND_CALIBRATE,  target: PC_CLEAR};
         PC_LOAD:   w = '{op: OP_LOAD,      cond: COND_NEVER,      target: PC_IDLE};
         PC_FOLD:   w = '{op: OP_FOLD,      cond: COND_OUT_RANGE,  target: PC_FOLD};
         PC_STORE:  w = '{op: OP_STORE,     cond: COND_NEVER,      target: PC_IDLE};
         PC_PULSE:  w = '{op: OP_PULSE,     cond: COND_COUNT_LEFT, target: PC_PULSE};
         PC_NEXT:   w = '{op: OP_NEXT_AXIS, cond: COND_AXIS_H,     target: PC_LOAD};
         PC_REPORT: w = '{op: OP_REPORT,    cond: COND_ALWAYS,     target: PC_IDLE};
         PC_CLEAR:  w = '{op: OP_CLEAR,     cond: COND_ALWAYS,     target: PC_REPORT};
         default:   w = '{op: OP_ACCEPT,    cond: COND_NEVER,      target: PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: hdl/stp_if.sv
// ----------------------------------------------------------------------------
// Stepper command driver channels
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface stp_req_if;
   import stp_pkg::*;

   logic             valid;
   logic             ready;
   logic             opcode;
   logic [CMD_W-1:0] command_byte;
   logic             calibrate_axis;

   modport source (output valid, output opcode, output command_byte,
                   output calibrate_axis, input ready);
   modport sink   (input valid, input opcode, input command_byte,
                   input calibrate_axis, output ready);
endinterface

interface stp_rsp_if;
   import stp_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        item_kind;
   logic                        pulse_axis;
   logic                        pulse_direction;
   logic signed [OUT_POS_W-1:0] horizontal_position;
   logic signed [OUT_POS_W-1:0] vertical_position;
   logic                        horizontal_dir_level;
   logic                        vertical_dir_level;
   logic                        horizontal_enable_level;
   logic                        vertical_enable_level;
   logic                        last;

   modport source (output valid, output item_kind, output pulse_axis,
                   output pulse_direction, output horizontal_position,
                   output vertical_position, output horizontal_dir_level,
                   output vertical_dir_level, output horizontal_enable_level,
                   output vertical_enable_level, output last, input ready);
   modport sink   (input valid, input item_kind, input pulse_axis,
                   input pulse_direction, input horizontal_position,
                   input vertical_position, input horizontal_dir_level,
                   input vertical_dir_level, input horizontal_enable_level,
                   input vertical_enable_level, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/two_axis_stepper_command_driver_unit.sv
// A calibrate clears the chosen axis and then reports; a move loads, folds,
// stores and pulses each axis in turn, plus one extra fold pass for an axis that wraps.
// One command is taken at a time; step pulses of both axes go through the
// shared pulse step, which holds when the result side stalls.
// Reset (synchronous, active high) zeroes positions, direction lines, driver
// enables and configuration, and empties the result register.
// ----------------------------------------------------------------------------
// Two-axis stepper command driver
// Decodes packed move bytes and calibrate commands, tracks both axis
// positions modulo one turn and emits step pulse and position report
// transactions under control of a small microprogram.
// ----------------------------------------------------------------------------
`default_nettype none

module two_axis_stepper_command_driver_unit #(
   parameter int STEPS_PER_TURN = stp_pkg::STEPS_PER_TURN_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_write_enable,
   input  wire  [stp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [stp_pkg::CSR_DATA_W-1:0]  csr_write_data,
   stp_req_if.sink                         req_ch,
   stp_rsp_if.source                       rsp_ch
);
   import stp_pkg::*;

   // Internal positions are wide enough for a folded position plus one
   // full move of seven steps in either direction.
   localparam int POS_W = $clog2(STEPS_PER_TURN + 8) + 1;
   localparam logic signed [POS_W-1:0] POS_TURN = POS_W'(STEPS_PER_TURN);
   localparam logic signed [POS_W-1:0] POS_HIGH = POS_W'(STEPS_PER_TURN / 2);
   localparam logic signed [POS_W-1:0] POS_LOW  =
      POS_W'(STEPS_PER_TURN / 2 - STEPS_PER_TURN + 1);

   // Configuration registers.
   logic h_pol_ff, h_pol_in;
   logic v_pol_ff, v_pol_in;
   logic en_low_ff, en_low_in;

   // Axis state.
   logic signed [POS_W-1:0] h_pos_ff, h_pos_in;
   logic signed [POS_W-1:0] v_pos_ff, v_pos_in;
   logic h_dir_ff, h_dir_in;
   logic v_dir_ff, v_dir_in;
   logic h_en_ff, h_en_in;
   logic v_en_ff, v_en_in;

   // Working registers of the current command.
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic                    cal_axis_ff, cal_axis_in;
   logic                    axis_ff, axis_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic signed [POS_W-1:0] work_ff, work_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic                 rsp_axis_ff, rsp_axis_in;
   logic                 rsp_dir_ff, rsp_dir_in;
   logic [OUT_POS_W-1:0] rsp_hpos_ff, rsp_hpos_in;
   logic [OUT_POS_W-1:0] rsp_vpos_ff, rsp_vpos_in;
   logic                 rsp_hdl_ff, rsp_hdl_in;
   logic                 rsp_vdl_ff, rsp_vdl_in;
   logic                 rsp_hel_ff, rsp_hel_in;
   logic                 rsp_vel_ff, rsp_vel_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Decode of the axis being worked on.
   logic                    nib_dir;
   logic [COUNT_W-1:0]      nib_cnt;
   logic                    nib_pol;
   logic                    move_level;
   logic signed [POS_W-1:0] pos_sel;
   logic signed [POS_W-1:0] step_mag;
   logic signed [POS_W-1:0] step_delta;
   logic                    work_high;
   logic                    work_low;
   logic                    slot_free;
   logic                    emit_pulse;
   logic                    emit_report;
   logic signed [31:0]      h_pos_wide;
   logic signed [31:0]      v_pos_wide;

   status_type status;
   ctrl_type   ctrl;

   stp_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // The command byte carries the horizontal nibble on top and the vertical
   // nibble below; each is a direction bit over a three-bit step count.
   always_comb begin
      if (axis_ff == AXIS_V) begin
         nib_dir = cmd_ff[3];
         nib_cnt = cmd_ff[2:0];
         nib_pol = v_pol_ff;
         pos_sel = v_pos_ff;
      end else begin
         nib_dir = cmd_ff[7];
         nib_cnt = cmd_ff[6:4];
         nib_pol = h_pol_ff;
         pos_sel = h_pos_ff;
      end
   end

   // A set polarity flips the sense of the direction bit. A move of zero
   // steps leaves the direction line low.
   assign move_level = (nib_cnt != '0) && (nib_dir ^ nib_pol);
   assign step_mag   = POS_W'(nib_cnt);
   assign step_delta = move_level ? step_mag : -step_mag;

   // Folding keeps a position in the window from one past minus half a
   // turn up to plus half a turn; each pass adds or removes one turn.
   assign work_high = work_ff > POS_HIGH;
   assign work_low  = work_ff < POS_LOW;

   assign slot_free   = !rsp_valid_ff || rsp_ch.ready;
   assign emit_pulse  = ctrl.go && (ctrl.op == OP_PULSE) && (count_ff != '0);
   assign emit_report = ctrl.go && (ctrl.op == OP_REPORT);

   // Positions leave the block as nine-bit two's complement, so a turn
   // of 512 steps or more wraps on output.
   assign h_pos_wide = 32'(h_pos_ff);
   assign v_pos_wide = 32'(v_pos_ff);

   always_comb begin
      status.req_valid     = req_ch.valid;
      status.req_calibrate = (req_ch.opcode == OPC_CALIBRATE);
      status.out_range     = work_high || work_low;
      status.count_nz      = (count_ff != '0);
      status.axis_v        = (axis_ff == AXIS_V);
      status.slot_free     = slot_free;
   end

   // The block takes a command only while the program sits at its idle step.
   assign req_ch.ready = (ctrl.op == OP_ACCEPT);

   // Configuration writes.
   always_comb begin
      h_pol_in  = h_pol_ff;
      v_pol_in  = v_pol_ff;
      en_low_in = en_low_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_H_POLARITY:    h_pol_in  = csr_write_data[0];
            CSR_V_POLARITY:    v_pol_in  = csr_write_data[0];
            CSR_ENABLE_ACT_LO: en_low_in = csr_write_data[0];
            default:           ;
         endcase
      end
   end

   // Datapath operations, one per program step.
   always_comb begin
      h_pos_in    = h_pos_ff;
      v_pos_in    = v_pos_ff;
      h_dir_in    = h_dir_ff;
      v_dir_in    = v_dir_ff;
      h_en_in     = h_en_ff;
      v_en_in     = v_en_ff;
      cmd_in      = cmd_ff;
      cal_axis_in = cal_axis_ff;
      axis_in     = axis_ff;
      count_in    = count_ff;
      work_in     = work_ff;
      if (ctrl.go) begin
         case (ctrl.op)
            OP_ACCEPT: begin
               cmd_in      = req_ch.command_byte;
               cal_axis_in = req_ch.calibrate_axis;
               axis_in     = AXIS_H;
            end
            OP_LOAD: begin
               // Enable the driver, set the direction line and start the
               // new position from the old one.
               work_in  = pos_sel + step_delta;
               count_in = nib_cnt;
               if (axis_ff == AXIS_V) begin
                  v_en_in  = 1'b1;
                  v_dir_in = move_level;
               end else begin
                  h_en_in  = 1'b1;
                  h_dir_in = move_level;
               end
            end
            OP_FOLD: begin
               if (work_high) begin
                  work_in = work_ff - POS_TURN;
               end else if (work_low) begin
                  work_in = work_ff + POS_TURN;
               end
            end
            OP_STORE: begin
               if (axis_ff == AXIS_V) begin
                  v_pos_in = work_ff;
               end else begin
                  h_pos_in = work_ff;
               end
            end
            OP_PULSE: begin
               if (count_ff != '0) begin
                  count_in = count_ff - COUNT_W'(1);
               end
            end
            OP_NEXT_AXIS: begin
               axis_in = ~axis_ff;
            end
            OP_CLEAR: begin
               if (cal_axis_ff == AXIS_V) begin
                  v_pos_in = '0;
               end else begin
                  h_pos_in = '0;
               end
            end
            default: ;
         endcase
      end
   end

   // Result register: loaded when a pulse or report is issued, emptied when
   // the sink takes the transaction.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_axis_in  = rsp_axis_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_hpos_in  = rsp_hpos_ff;
      rsp_vpos_in  = rsp_vpos_ff;
      rsp_hdl_in   = rsp_hdl_ff;
      rsp_vdl_in   = rsp_vdl_ff;
      rsp_hel_in   = rsp_hel_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_pulse || emit_report) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit_report ? KIND_REPORT : KIND_PULSE;
         rsp_axis_in  = emit_report ? AXIS_H : axis_ff;
         rsp_dir_in   = emit_report ? 1'b0 : ((axis_ff == AXIS_V) ? v_dir_ff : h_dir_ff);
         rsp_hpos_in  = h_pos_wide[OUT_POS_W-1:0];
         rsp_vpos_in  = v_pos_wide[OUT_POS_W-1:0];
         rsp_hdl_in   = h_dir_ff;
         rsp_vdl_in   = v_dir_ff;
         rsp_hel_in   = h_en_ff ^ en_low_ff;
         rsp_vel_in   = v_en_ff ^ en_low_ff;
         rsp_last_in  = emit_report;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_pol_ff     <= 1'b0;
         v_pol_ff     <= 1'b0;
         en_low_ff    <= 1'b0;
         h_pos_ff     <= '0;
         v_pos_ff     <= '0;
         h_dir_ff     <= 1'b0;
         v_dir_ff     <= 1'b0;
         h_en_ff      <= 1'b0;
         v_en_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         h_pol_ff     <= h_pol_in;
         v_pol_ff     <= v_pol_in;
         en_low_ff    <= en_low_in;
         h_pos_ff     <= h_pos_in;
         v_pos_ff     <= v_pos_in;
         h_dir_ff     <= h_dir_in;
         v_dir_ff     <= v_dir_in;
         h_en_ff      <= h_en_in;
         v_en_ff      <= v_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      cal_axis_ff <= cal_axis_in;
      axis_ff     <= axis_in;
      count_ff    <= count_in;
      work_ff     <= work_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_axis_ff <= rsp_axis_in;
      rsp_dir_ff  <= rsp_dir_in;
      rsp_hpos_ff <= rsp_hpos_in;
      rsp_vpos_ff <= rsp_vpos_in;
      rsp_hdl_ff  <= rsp_hdl_in;
      rsp_vdl_ff  <= rsp_vdl_in;
      rsp_hel_ff  <= rsp_hel_in;
      rsp_vel_ff  <= rsp_vel_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid                   = rsp_valid_ff;
   assign rsp_ch.item_kind               = rsp_kind_ff;
   assign rsp_ch.pulse_axis              = rsp_axis_ff;
   assign rsp_ch.pulse_direction         = rsp_dir_ff;
   assign rsp_ch.horizontal_position     = rsp_hpos_ff;
   assign rsp_ch.vertical_position       = rsp_vpos_ff;
   assign rsp_ch.horizontal_dir_level    = rsp_hdl_ff;
   assign rsp_ch.vertical_dir_level      = rsp_vdl_ff;
   assign rsp_ch.horizontal_enable_level = rsp_hel_ff;
   assign rsp_ch.vertical_enable_level   = rsp_vel_ff;
   assign rsp_ch.last                    = rsp_last_ff;

`ifndef ASSERT_OFF
   // A command transaction starts the program, so the block is busy next.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("command taken while a command is in progress");

   // Stored positions always lie inside the folded window.
   a_pos_folded: assert property (@(posedge clock) disable iff (reset)
      (h_pos_ff >= POS_LOW) && (h_pos_ff <= POS_HIGH) &&
      (v_pos_ff >= POS_LOW) && (v_pos_ff <= POS_HIGH))
      else $error("axis position outside the folded window");

   // A pulse is only issued for an axis whose driver is enabled.
   a_pulse_enabled: assert property (@(posedge clock) disable iff (reset)
      emit_pulse |-> ((axis_ff == AXIS_V) ? v_en_ff : h_en_ff))
      else $error("step pulse on a disabled driver");

   // The report closes a command and carries fixed pulse fields.
   a_report_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.last) |->
         (rsp_ch.item_kind == KIND_REPORT) && (rsp_ch.pulse_axis == AXIS_H) &&
         !rsp_ch.pulse_direction)
      else $error("malformed position report");
`endif

endmodule

`default_nettype wire

// File: hdl/stp_seq.sv
// ----------------------------------------------------------------------------
// Stepper command driver sequencer
// Program counter and control store; picks the next step from the jump
// condition and holds a step while it waits on a handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_seq (
   input  wire                  clock,
   input  wire                  reset,
   input  stp_pkg::status_type  status,
   output stp_pkg::ctrl_type    ctrl
);
   import stp_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   ucode_type       uword;
   logic            hold;
   logic            take_jump;

   assign uword = ucode_rom(pc_ff);

   // A step holds while its handshake is not ready.
   always_comb begin
      hold = 1'b0;
      case (uword.op)
         OP_ACCEPT: hold = !status.req_valid;
         OP_PULSE:  hold = status.count_nz && !status.slot_free;
         OP_REPORT: hold = !status.slot_free;
         default:   hold = 1'b0;
      endcase
   end

   always_comb begin
      take_jump = 1'b0;
      case (uword.cond)
         COND_NEVER:      take_jump = 1'b0;
         COND_ALWAYS:     take_jump = 1'b1;
         COND_CALIBRATE:  take_jump = status.req_calibrate;
         COND_OUT_RANGE:  take_jump = status.out_range;
         COND_COUNT_LEFT: take_jump = status.count_nz;
         COND_AXIS_H:     take_jump = !status.axis_v;
         default:         take_jump = 1'b0;
      endcase
   end

   // Next step.
   always_comb begin
      if (hold) begin
         pc_in = pc_ff;
      end else if (take_jump) begin
         pc_in = uword.target;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   // Control outputs.
   always_comb begin
      ctrl.op = uword.op;
      ctrl.go = !hold;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire
